@@ sv/vertex_layout_calculator_core_assert.svh @@
`ifndef VERTEX_LAYOUT_CALCULATOR_CORE_ASSERT_SVH
`define VERTEX_LAYOUT_CALCULATOR_CORE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define VLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex layout assertion failed");

// Checks that a condition implies a consequence in the following cycle.
`define VLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex layout assertion failed");

`endif

@@ sv/vlc_pkg.sv @@
`default_nettype none

package vlc_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic [2:0] morph_count_less_one;
    logic [1:0] position_format;
    logic [1:0] normal_format;
    logic [2:0] color_format;
    logic [1:0] texcoord_format;
    logic [2:0] weight_count_less_one;
    logic [1:0] weight_format;
  } fmt_t;

  typedef struct packed {
    logic [6:0] first_padding_offset;
    logic [5:0] position_offset;
    logic [9:0] vertex_stride;
  } res_t;

  typedef struct packed {
    logic [6:0] size;
    logic [2:0] largest;
    logic [6:0] pad_at;
    logic       padded;
  } lay_t;

  // Alignment of weights, texture coordinates and normals.
  function automatic logic [2:0] fmt_align(logic [1:0] f);
    logic [2:0] a;
    unique case (f)
      2'd0: a = 3'd0;
      2'd1: a = 3'd1;
      2'd2: a = 3'd2;
      default: a = 3'd4;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] tex_bytes(logic [1:0] f);
    logic [3:0] b;
    unique case (f)
      2'd0: b = 4'd0;
      2'd1: b = 4'd2;
      2'd2: b = 4'd4;
      default: b = 4'd8;
    endcase
    return b;
  endfunction

  // Colour size equals its alignment.
  function automatic logic [2:0] col_bytes(logic [2:0] f);
    logic [2:0] b;
    unique case (f)
      3'd4, 3'd5, 3'd6: b = 3'd2;
      3'd7: b = 3'd4;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] nrm_bytes(logic [1:0] f);
    logic [3:0] b;
    unique case (f)
      2'd0: b = 4'd0;
      2'd1: b = 4'd3;
      2'd2: b = 4'd6;
      default: b = 4'd12;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] pos_bytes(logic [1:0] f);
    logic [3:0] b;
    unique case (f)
      2'd0, 2'd1: b = 4'd3;
      2'd2: b = 4'd6;
      default: b = 4'd12;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] pos_align(logic [1:0] f);
    logic [2:0] a;
    unique case (f)
      2'd0, 2'd1: a = 3'd1;
      2'd2: a = 3'd2;
      default: a = 3'd4;
    endcase
    return a;
  endfunction

  // Rounds x up to a multiple of a; an alignment of zero leaves x alone.
  function automatic logic [6:0] round_up(logic [6:0] x, logic [2:0] a);
    logic [7:0] sum;
    logic [7:0] mask;
    if (a == 3'd0) begin
      return x;
    end
    sum  = {1'b0, x} + {5'b0, a} - 8'd1;
    mask = ~({5'b0, a} - 8'd1);
    return 7'(sum & mask);
  endfunction

  function automatic lay_t align_to(lay_t l, logic [2:0] a);
    logic [6:0] r;
    r = round_up(l.size, a);
    if (!l.padded && (r != l.size)) begin
      l.padded = 1'b1;
      l.pad_at = l.size;
    end
    l.size = r;
    return l;
  endfunction

  function automatic lay_t place(lay_t l, logic [2:0] a, logic [3:0] bytes);
    lay_t n;
    n = align_to(l, a);
    n.size = n.size + {3'b0, bytes};
    if (a > n.largest) begin
      n.largest = a;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/vlc_layout.sv @@
`default_nettype none

module vlc_layout (
  input  vlc_pkg::fmt_t fmt,
  output vlc_pkg::res_t res
);
  import vlc_pkg::*;

  lay_t       lay;
  logic [6:0] wsize;
  logic [6:0] pos_off;
  logic [3:0] mc;

  always_comb begin
    mc    = {1'b0, fmt.morph_count_less_one} + 4'd1;
    wsize = 7'({4'b0, fmt_align(fmt.weight_format)} *
               {4'b0, {1'b0, fmt.weight_count_less_one} + 4'd1});
    lay     = '0;
    pos_off = '0;

    // Weights start at offset zero and need no alignment.
    if (fmt.weight_format != 2'd0) begin
      lay.size    = wsize;
      lay.largest = fmt_align(fmt.weight_format);
    end
    if (fmt.texcoord_format != 2'd0) begin
      lay = place(lay, fmt_align(fmt.texcoord_format), tex_bytes(fmt.texcoord_format));
    end
    if (fmt.color_format != 3'd0) begin
      lay = place(lay, col_bytes(fmt.color_format), {1'b0, col_bytes(fmt.color_format)});
    end
    if (fmt.normal_format != 2'd0) begin
      lay = place(lay, fmt_align(fmt.normal_format), nrm_bytes(fmt.normal_format));
    end
    if (fmt.position_format != 2'd0) begin
      lay     = place(lay, pos_align(fmt.position_format), pos_bytes(fmt.position_format));
      pos_off = lay.size - {3'b0, pos_bytes(fmt.position_format)};
    end
    lay = align_to(lay, lay.largest);

    res.vertex_stride        = 10'({4'b0, lay.size} * {7'b0, mc});
    res.position_offset      = pos_off[5:0];
    res.first_padding_offset = lay.padded ? lay.pad_at : 7'd0;
  end

endmodule

`default_nettype wire

@@ sv/vertex_layout_calculator_core.sv @@
// Path: a beat accepted into the input register goes through the layout logic
// and is then captured in the result register, which drives the output.
// Throughput: one beat per cycle; the input register and the result register
// advance together, so a stall on the output side only stops the input when
// both registers are full.
// Reset: synchronous, active low; it clears both valid flags, data is kept.
`default_nettype none

`include "vertex_layout_calculator_core_assert.svh"

module vertex_layout_calculator_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // Fields from bit 0 up: weight_format[1:0], weight_count_less_one[4:2],
  // texcoord_format[6:5], color_format[9:7], normal_format[11:10],
  // position_format[13:12], morph_count_less_one[16:14], zero fill above.
  input  wire  [vlc_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // Fields from bit 0 up: vertex_stride[9:0], position_offset[15:10],
  // first_padding_offset[22:16], zero fill above.
  output logic [vlc_pkg::OutDataW-1:0] out_tdata
);
  import vlc_pkg::*;

  // The first stage holds the captured format codes, the second the
  // finished layout. All the layout arithmetic sits between them.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  fmt_t  s1_fmt_r;
  logic  out_valid_r;
  logic  out_valid_nxt;
  res_t  out_res_r;
  res_t  res;
  logic  out_free;
  logic  in_fire;

  // The result register can take a new value when it is empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  vlc_layout u_layout (
    .fmt (s1_fmt_r),
    .res (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? s1_valid_r : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_fmt_r <= fmt_t'(in_tdata[$bits(fmt_t)-1:0]);
    end
    if (out_free && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, out_res_r};

  // A captured beat always moves into the result register when it has room.
  `VLC_ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_valid_r && out_free, out_valid_r)
  // An accepted beat is held in the first stage on the next cycle.
  `VLC_ASSERT_NEXT(a_in_held, clk, rst_n, in_fire, s1_valid_r)
  // Padding can only be recorded below the final stride.
  `VLC_ASSERT_SAME(a_pad_below_stride, clk, rst_n,
    out_valid_r && (out_res_r.first_padding_offset != 7'd0),
    {3'b0, out_res_r.first_padding_offset} < out_res_r.vertex_stride)
  // The position lies inside the stride unless the stride is zero.
  `VLC_ASSERT_SAME(a_pos_in_stride, clk, rst_n,
    out_valid_r,
    {4'b0, out_res_r.position_offset} < out_res_r.vertex_stride ||
    out_res_r.vertex_stride == 10'd0)

endmodule

`default_nettype wire
